FILE: rtl/stid_pkg.sv
// Package for the sorted table core: status and request codes, field widths
// and the default table capacity. No dependencies.
package stid_pkg;

    // Default number of cells in the table.
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths.
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Request codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_op;

    // Per-cell position information derived from the fill count.
    typedef struct packed {
        logic occ;
        logic at_end;
    } t_cell_pos;

    // Comparison flags a cell hands to its right neighbour and the top level.
    typedef struct packed {
        logic gt;
        logic ge;
        logic hit;
    } t_cell_flags;

endpackage

FILE: rtl/sorted_table_insert_delete_core.sv
// Sorted table core: a chain of CAPACITY cells kept in ascending signed order.
// A request is taken only in the idle state, so no new request is accepted until
// the result word of the last one is taken. The steps are the cell update, the
// readout of minimum and maximum and the output handshake, which waits for the receiver.
// Reset (synchronous, active low) empties the table and clears the handshake;
// the cell contents are left as they are and are ignored until written.
module sorted_table_insert_delete_core
    import stid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  logic                       i_req_type,
    input  logic signed [VALUE_W-1:0]  i_req_value,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic        [STATUS_W-1:0] o_status,
    output logic        [COUNT_W-1:0]  o_entry_count,
    output logic signed [VALUE_W-1:0]  o_min_value,
    output logic signed [VALUE_W-1:0]  o_max_value
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [STATUS_W-1:0]       r_status;
    logic [STATUS_W-1:0]       n_status;
    logic [STATUS_W-1:0]       r_out_status;
    logic [COUNT_W-1:0]        r_out_count;
    logic signed [VALUE_W-1:0] r_out_min;
    logic signed [VALUE_W-1:0] r_out_max;

    logic                      accept;
    logic                      full;
    logic                      found;
    logic signed [VALUE_W-1:0] last_value;
    t_cell_op                  op;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    t_cell_flags               cell_flags [CAPACITY];
    t_cell_pos                 cell_pos   [CAPACITY];
    logic [CAPACITY-1:0]       cell_hit;
    logic [CAPACITY-1:0]       cell_last;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign full        = (r_count == CNT_W'(CAPACITY));
    assign found       = |cell_hit;

    // Operation broadcast to the cells; refused requests change nothing.
    always_comb begin
        op.ins = accept && (i_req_type == REQ_INSERT) && !full;
        op.del = accept && (i_req_type == REQ_DELETE) && found;
    end

    // Chain of cells; the first sees zero on its left, the last sees its own word on its right.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;
        t_cell_flags               left_flags;

        if (g == 0) begin : g_first
            assign left_value = '0;
            assign left_flags = '0;
        end else begin : g_inner
            assign left_value = cell_value[g-1];
            assign left_flags = cell_flags[g-1];
        end

        if (g == CAPACITY - 1) begin : g_final
            assign right_value = cell_value[g];
        end else begin : g_more
            assign right_value = cell_value[g+1];
        end

        assign cell_pos[g].occ    = (CNT_W'(g) < r_count);
        assign cell_pos[g].at_end = (CNT_W'(g) == r_count);
        assign cell_hit[g]        = cell_flags[g].hit;
        assign cell_last[g]       = (CNT_W'(g + 1) == r_count);

        stid_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (op),
            .i_pos         (cell_pos[g]),
            .i_req_value   (i_req_value),
            .i_left_value  (left_value),
            .i_left_flags  (left_flags),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_flags       (cell_flags[g])
        );
    end

    // Pick the word of the last occupied cell with a one-hot AND-OR.
    always_comb begin
        last_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            last_value = last_value | (cell_value[k] & {VALUE_W{cell_last[k]}});
        end
    end

    // Status and fill count for the accepted request.
    always_comb begin
        n_status = r_status;
        n_count  = r_count;
        if (accept) begin
            if (i_req_type == REQ_INSERT) begin
                n_status = full ? ST_FULL : ST_INSERTED;
                if (!full) begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                n_status = found ? ST_DELETED : ST_NOT_FOUND;
                if (found) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    // Sequencer: update the cells, read back the ends, hand out the word.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Result registers; loaded once the cells hold the updated table.
    // The count field keeps the low bits of the fill count, zero-extended
    // when the table is small.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (r_state == S_READ) begin
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
            if (r_count == '0) begin
                r_out_min <= '0;
                r_out_max <= '0;
            end else begin
                r_out_min <= cell_value[0];
                r_out_max <= last_value;
            end
        end
    end

    assign o_res_valid   = (r_state == S_OUT);
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_min_value   = r_out_min;
    assign o_max_value   = r_out_max;

endmodule

FILE: rtl/stid_cell.sv
// One cell of the sorted table: holds a single value, compares it with the
// request and shifts to or from its neighbours. Depends on stid_pkg.
module stid_cell
    import stid_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_op                  i_op,
    input  t_cell_pos                 i_pos,
    input  logic signed [VALUE_W-1:0] i_req_value,
    input  logic signed [VALUE_W-1:0] i_left_value,
    input  t_cell_flags               i_left_flags,
    input  logic signed [VALUE_W-1:0] i_right_value,
    output logic signed [VALUE_W-1:0] o_value,
    output t_cell_flags               o_flags
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // Compare the stored value with the request; empty cells never match.
    always_comb begin
        o_flags.gt  = i_pos.occ && (r_value > i_req_value);
        o_flags.ge  = i_pos.occ && !(r_value < i_req_value);
        o_flags.hit = i_pos.occ && (r_value == i_req_value) && !i_left_flags.ge;
    end

    // On insert, cells past the slot take the left word and the slot takes
    // the request; on delete, cells from the match onwards take the right word.
    always_comb begin
        n_value = r_value;
        if (i_op.ins) begin
            if (i_left_flags.gt) begin
                n_value = i_left_value;
            end else if (o_flags.gt || i_pos.at_end) begin
                n_value = i_req_value;
            end
        end else if (i_op.del) begin
            if (o_flags.ge) begin
                n_value = i_right_value;
            end
        end
    end

    // The stored word is payload and is not reset.
    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

FILE: sim/sorted_table_insert_delete_core_tb.sv
// Self-checking testbench for sorted_table_insert_delete_core: directed and random
// insert and delete words are compared against a shadow sorted table.
// Depends on rtl/stid_pkg.sv and rtl/sorted_table_insert_delete_core.sv.
`timescale 1ns / 100ps

module sorted_table_insert_delete_core_tb;
    import stid_pkg::*;

    localparam int TABLE_DEPTH  = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 450;
    localparam int POOL_SIZE    = 10;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } t_table_req;

    typedef struct {
        logic        [STATUS_W-1:0] status;
        logic        [COUNT_W-1:0]  count;
        logic signed [VALUE_W-1:0]  min_v;
        logic signed [VALUE_W-1:0]  max_v;
    } t_table_answer;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_type  = REQ_INSERT;
    logic signed [VALUE_W-1:0]  req_value = '0;
    logic                       res_ready = 1'b0;
    logic                       req_ready;
    logic                       res_valid;
    logic        [STATUS_W-1:0] res_status;
    logic        [COUNT_W-1:0]  res_count;
    logic signed [VALUE_W-1:0]  res_min;
    logic signed [VALUE_W-1:0]  res_max;

    // Words waiting to be sent, and answers waiting to come back.
    t_table_req    request_q[$];
    t_table_answer answer_q[$];

    // Shadow copy of the sorted table.
    logic signed [VALUE_W-1:0] shadow_cells [TABLE_DEPTH];
    int                        shadow_count = 0;

    int src_idle_pct  = 35;
    int snk_stall_pct = 81;
    int n_accepted    = 0;
    int n_errors      = 0;
    int cycle_count   = 0;
    int n_inserted    = 0;
    int n_deleted     = 0;
    int n_missing     = 0;
    int n_refused     = 0;
    int peak_count    = 0;

    sorted_table_insert_delete_core #(
        .CAPACITY(TABLE_DEPTH)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .o_req_ready  (req_ready),
        .i_req_type   (req_type),
        .i_req_value  (req_value),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_status     (res_status),
        .o_entry_count(res_count),
        .o_min_value  (res_min),
        .o_max_value  (res_max)
    );

    // Clock and cycle counter.
    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Applies one request to the shadow table and returns the answer it should give.
    function automatic t_table_answer predict_table_answer(t_table_req rq);
        t_table_answer ans;
        int            pos;
        int            i;
        logic          found;
        found = 1'b0;
        pos   = shadow_count;
        if (rq.kind == REQ_INSERT) begin
            if (shadow_count >= TABLE_DEPTH) begin
                ans.status = ST_FULL;
            end else begin
                // New copy goes after every entry that is not greater.
                for (i = 0; i < shadow_count; i++) begin
                    if (!found && shadow_cells[i] > rq.value) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (i = shadow_count; i > pos; i--) begin
                    shadow_cells[i] = shadow_cells[i-1];
                end
                shadow_cells[pos] = rq.value;
                shadow_count++;
                ans.status = ST_INSERTED;
            end
        end else begin
            // Lowest-index equal entry is the one removed.
            for (i = 0; i < shadow_count; i++) begin
                if (!found && shadow_cells[i] == rq.value) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                ans.status = ST_NOT_FOUND;
            end else begin
                for (i = pos; i + 1 < shadow_count; i++) begin
                    shadow_cells[i] = shadow_cells[i+1];
                end
                shadow_count--;
                ans.status = ST_DELETED;
            end
        end
        ans.count = COUNT_W'(shadow_count);
        if (shadow_count == 0) begin
            ans.min_v = '0;
            ans.max_v = '0;
        end else begin
            ans.min_v = shadow_cells[0];
            ans.max_v = shadow_cells[shadow_count-1];
        end
        return ans;
    endfunction

    task automatic queue_request(logic kind, logic signed [VALUE_W-1:0] value);
        t_table_req rq;
        rq.kind  = kind;
        rq.value = value;
        request_q.push_back(rq);
    endtask

    task automatic check_field(string fname, logic [VALUE_W-1:0] want,
                               logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", fname, want, got);
            n_errors++;
        end
    endtask

    // Request driver: holds each word until it is taken, then maybe idles.
    always @(posedge clk) begin : req_driver
        t_table_req cur_req;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) begin
                answer_q.push_back(predict_table_answer(cur_req));
                n_accepted++;
            end
            if (!req_valid || req_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_req = request_q.pop_front();
                    req_valid <= 1'b1;
                    req_type  <= cur_req.kind;
                    req_value <= cur_req.value;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken word with the oldest expected answer.
    always @(posedge clk) begin : res_monitor
        t_table_answer want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (answer_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    n_errors++;
                end else begin
                    want = answer_q.pop_front();
                    check_field("status", VALUE_W'(want.status), VALUE_W'(res_status));
                    check_field("entry_count", VALUE_W'(want.count), VALUE_W'(res_count));
                    check_field("min_value", want.min_v, res_min);
                    check_field("max_value", want.max_v, res_max);
                    case (want.status)
                        ST_INSERTED:  n_inserted++;
                        ST_DELETED:   n_deleted++;
                        ST_NOT_FOUND: n_missing++;
                        default:      n_refused++;
                    endcase
                    if (int'(want.count) > peak_count) peak_count = int'(want.count);
                end
            end
            res_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic signed [VALUE_W-1:0] pool [POOL_SIZE];
        int                        n_made;
        int                        burst_len;
        int                        ins_pct;
        int                        total;
        int                        k;
        logic                      kind;
        logic signed [VALUE_W-1:0] value;

        // Directed part: empty table, extremes, duplicates, full table, absent value.
        queue_request(REQ_DELETE, 32'sd5);
        queue_request(REQ_INSERT, 32'sh7FFFFFFF);
        queue_request(REQ_INSERT, 32'sh7FFFFFFF);
        queue_request(REQ_INSERT, 32'sh80000000);
        queue_request(REQ_INSERT, 32'sh80000000);
        queue_request(REQ_INSERT, 32'sd0);
        queue_request(REQ_INSERT, -32'sd1);
        queue_request(REQ_INSERT, 32'sd1);
        queue_request(REQ_DELETE, 32'sh12345678);
        queue_request(REQ_DELETE, 32'sh7FFFFFFF);
        queue_request(REQ_INSERT, 32'sh55555555);
        queue_request(REQ_INSERT, 32'shAAAAAAAA);
        queue_request(REQ_INSERT, 32'sd100);
        queue_request(REQ_INSERT, -32'sd100);
        queue_request(REQ_INSERT, 32'sd0);
        queue_request(REQ_INSERT, 32'sd7);
        queue_request(REQ_INSERT, 32'sd7);
        queue_request(REQ_INSERT, 32'sh0F0F0F0F);
        queue_request(REQ_INSERT, 32'shF0F0F0F0);
        queue_request(REQ_INSERT, 32'sd42);
        queue_request(REQ_DELETE, 32'sh80000000);
        queue_request(REQ_DELETE, 32'sh80000000);
        queue_request(REQ_DELETE, 32'sh7FFFFFFF);

        // Random part: bursts that fill, drain or churn the table. A small value
        // pool makes deletes and duplicates hit; full-range values are the noise.
        pool[0] = 32'sh80000000;
        pool[1] = 32'sh7FFFFFFF;
        pool[2] = 32'sd0;
        for (k = 3; k < POOL_SIZE; k++) pool[k] = $urandom;
        n_made = 0;
        while (n_made < RANDOM_ITEMS) begin
            burst_len = $urandom_range(30, 8);
            case ($urandom_range(2))
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            pool[$urandom_range(POOL_SIZE-1, 3)] = $urandom;
            for (k = 0; k < burst_len && n_made < RANDOM_ITEMS; k++) begin
                kind  = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_DELETE;
                value = ($urandom_range(99) < 65) ? pool[$urandom_range(POOL_SIZE-1)]
                                                  : $signed($urandom);
                queue_request(kind, value);
                n_made++;
            end
        end
        total = request_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Idling phases: sender gaps with a slow receiver, then the reverse, then none.
        while (n_accepted < total / 3) @(posedge clk);
        src_idle_pct  <= 81;
        snk_stall_pct <= 35;
        while (n_accepted < (2 * total) / 3) @(posedge clk);
        src_idle_pct  <= 0;
        snk_stall_pct <= 0;

        while (request_q.size() != 0 || req_valid || answer_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests: %0d inserted, %0d deleted, %0d absent, %0d refused.",
                 n_accepted, n_inserted, n_deleted, n_missing, n_refused);
        $display("Table reached %0d of %0d entries; %0d mismatches seen.",
                 peak_count, TABLE_DEPTH, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
